/* sv/i2cms_pkg.sv */
// i2c master bit sequencer: shared types, opcodes and the phase length table
// no dependencies
package i2cms_pkg;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_ACK   = 3'd3,
    OP_NACK  = 3'd4,
    OP_WACK  = 3'd5,
    OP_WRITE = 3'd6,
    OP_READ  = 3'd7
  } op_e;

  localparam int unsigned PhaseW = 6;
  localparam int unsigned InW    = 16;
  localparam int unsigned OutW   = 16;

  function automatic logic [PhaseW-1:0] phase_len(input op_e op);
    logic [PhaseW-1:0] len;
    unique case (op)
      OP_START: len = 6'd2;
      OP_STOP:  len = 6'd2;
      OP_ACK:   len = 6'd5;
      OP_NACK:  len = 6'd3;
      OP_WACK:  len = 6'd3;
      OP_WRITE: len = 6'd32;
      OP_READ:  len = 6'd24;
      default:  len = 6'd0;
    endcase
    return len;
  endfunction

endpackage

/* sv/i2c_master_bit_sequencer_top.sv */
// i2c master bit sequencer top level: one tick word in, one line-level word out
// depends on i2cms_pkg
//
// Each input word is one tick of the bus timing. When idle, a nonzero opcode
// starts a command (start, stop, ack, nack, wait ack, write byte, read byte)
// that then steps SCL/SDA through its phases, one phase per accepted word.
// Every word produces exactly one output word, registered when it is taken; a
// new word is accepted each cycle unless the output register is full and not
// being drained, so sustained rate is one word per clock. The output word is
// held in the single result register. A command word arriving while busy is
// dropped and flagged in the rejected bit.
module i2c_master_bit_sequencer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [2:0] opcode, [10:3] tx_byte, [11] sda_in, [15:12] zero
  input  logic [i2cms_pkg::InW-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] nack_seen, [13] rejected, [15:14] zero
  output logic [i2cms_pkg::OutW-1:0] m_axis_tdata
);
  import i2cms_pkg::*;

  op_e               cmd_q, cmd_d, cmd;
  logic [PhaseW-1:0] phase_q, phase_d, p, p_next;
  logic [1:0]        m3_q, m3_d, m3;
  logic [7:0]        shift_q, shift_d, sh;
  logic              scl_q, scl_d, sda_q, sda_d, ack_q, ack_d;
  logic [7:0]        rd_q, rd_d;
  logic [OutW-1:0]   out_q, out_d;
  logic              ovalid_q;

  op_e        in_op;
  logic [7:0] in_tx;
  logic       in_sda, accept, start, reject, done;

  assign in_op  = op_e'(s_axis_tdata[2:0]);
  assign in_tx  = s_axis_tdata[10:3];
  assign in_sda = s_axis_tdata[11];

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    start  = (in_op != OP_IDLE) && (cmd_q == OP_IDLE);
    reject = (in_op != OP_IDLE) && (cmd_q != OP_IDLE);
    cmd    = start ? in_op : cmd_q;
    p      = start ? '0 : phase_q;
    m3     = start ? 2'd0 : m3_q;
    sh     = start ? ((in_op == OP_WRITE) ? in_tx : 8'h00) : shift_q;
    p_next = p + 6'd1;

    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    shift_d = sh;
    rd_d    = rd_q;
    cmd_d   = cmd;
    phase_d = p;
    m3_d    = m3;
    done    = 1'b0;

    unique case (cmd)
      OP_START: begin
        scl_d = 1'b1;
        sda_d = (p == '0);
      end
      OP_STOP: begin
        scl_d = 1'b1;
        sda_d = (p != '0);
      end
      OP_ACK: begin
        scl_d = (p == 6'd2);
        sda_d = (p == '0) || (p == 6'd4);
      end
      OP_NACK: begin
        sda_d = 1'b1;
        scl_d = (p == 6'd1);
      end
      OP_WACK: begin
        sda_d = 1'b1;
        scl_d = (p == 6'd1);
        if (p == 6'd1) ack_d = in_sda;
      end
      OP_WRITE: begin
        unique case (p[1:0])
          2'd0: begin
            sda_d = 1'b0;
            scl_d = 1'b0;
          end
          2'd1: begin
            sda_d = sh[7];
            scl_d = 1'b0;
          end
          2'd2: scl_d = 1'b1;
          default: begin
            scl_d   = 1'b0;
            shift_d = {sh[6:0], 1'b0};
          end
        endcase
      end
      OP_READ: begin
        sda_d = 1'b1;
        scl_d = (m3 == 2'd1);
        if (m3 == 2'd1) shift_d = {sh[6:0], in_sda};
      end
      default: ;
    endcase

    if (cmd != OP_IDLE) begin
      phase_d = p_next;
      m3_d    = (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
      if (p_next >= phase_len(cmd)) begin
        done    = 1'b1;
        cmd_d   = OP_IDLE;
        phase_d = '0;
        m3_d    = 2'd0;
        if (cmd == OP_READ) rd_d = shift_d;
      end
    end

    out_d = {2'b00, reject, ack_d, rd_d, done, (cmd_d != OP_IDLE), sda_d, scl_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= OP_IDLE;
      phase_q  <= '0;
      m3_q     <= 2'd0;
      shift_q  <= 8'h00;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      ack_q    <= 1'b0;
      rd_q     <= 8'h00;
      ovalid_q <= 1'b0;
    end else begin
      if (accept) begin
        cmd_q   <= cmd_d;
        phase_q <= phase_d;
        m3_q    <= m3_d;
        shift_q <= shift_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        ack_q   <= ack_d;
        rd_q    <= rd_d;
      end
      if (accept) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q == OP_IDLE) |-> (phase_q == '0 && m3_q == 2'd0))
    else $error("phase counter not cleared while idle");

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q != OP_IDLE) |-> (phase_q < phase_len(cmd_q)))
    else $error("phase counter past command length");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_q[3]) |-> !out_q[2])
    else $error("done and busy reported together");

  a_reject_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_q != OP_IDLE && in_op != OP_IDLE) |=> out_q[13])
    else $error("command while busy not flagged");
`endif

endmodule
